@@ rtl/lws_pkg.sv @@
`default_nettype none

package lws_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;

    localparam int MAG_W   = 16;
    localparam int VALUE_W = 17;
    localparam int FRAC_W  = 15;
    localparam int PROD_W  = 28;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [MAG_W-1:0] Q15_ONE = 16'h8000;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] LOG10_2_Q30 = 64'd323228497;

    localparam logic [1:0] CURVE_SQUARE = 2'd0;
    localparam logic [1:0] CURVE_SINE   = 2'd1;
    localparam logic [1:0] CURVE_LOG    = 2'd2;

    localparam logic CMD_ENVELOPE = 1'b0;
    localparam logic CMD_SAMPLE   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_CURVE_SELECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_AMOUNT   = 2'd1;

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic [MAG_W-1:0]  mag;
        logic              neg;
        logic [1:0]        sel;
        logic [MAG_W-1:0]  w;
    } idx_t;

    typedef struct packed {
        logic [MAG_W-1:0] wet;
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic [MAG_W-1:0] w;
    } wet_t;

    function automatic logic [MAG_W-1:0] clamp_q15(input logic [63:0] v);
        logic [MAG_W-1:0] r;
        r = (v > 64'(Q15_ONE)) ? Q15_ONE : v[MAG_W-1:0];
        return r;
    endfunction

    function automatic logic [MAG_W-1:0] square_point(input logic [63:0] t);
        logic [63:0] sq;
        sq = (t * t) >> 45;
        return clamp_q15(sq);
    endfunction

    function automatic logic [MAG_W-1:0] sine_point(input logic [63:0] t);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x    = (t * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int k = 1; k <= 7; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                sum = (term > sum) ? 64'd0 : sum - term;
            else
                sum = sum + term;
        end
        return clamp_q15(sum >> 15);
    endfunction

    function automatic logic [MAG_W-1:0] log_point(input logic [63:0] t);
        logic [63:0] y;
        logic [63:0] e;
        logic [63:0] frac;
        logic [63:0] r;
        y    = Q30_ONE + 64'd9 * t;
        e    = 64'd0;
        frac = 64'd0;
        for (int h = 0; h < 8; h++)
        begin
            if (y >= 2 * Q30_ONE)
            begin
                y = y >> 1;
                e = e + 64'd1;
            end
        end
        for (int b = 0; b < 30; b++)
        begin
            y    = (y * y) >> 30;
            frac = frac << 1;
            if (y >= 2 * Q30_ONE)
            begin
                y    = y >> 1;
                frac = frac | 64'd1;
            end
        end
        r = (((e << 30) + frac) * LOG10_2_Q30) >> 45;
        return clamp_q15(r);
    endfunction

endpackage

`default_nettype wire

@@ rtl/lws_if.sv @@
`default_nettype none

interface lws_req_if;
    import lws_pkg::*;

    logic               valid;
    logic               ready;
    logic               command;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink (input valid, input command, input value, output ready);
endinterface

interface lws_res_if;
    import lws_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] shaped_value;

    modport source (output valid, output shaped_value, input ready);
    modport sink (input valid, input shaped_value, output ready);
endinterface

`default_nettype wire

@@ rtl/lut_waveshaper_mix.sv @@
// data path: an accepted item moves through stage registers s1 to s7 in order,
//   and its result is held in the output register s7 until it is taken
// throughput: one item per cycle unless the output is held; seven register stages,
//   each holding at most one table read pair or one pair of 16x16 multipliers
// reset: clears all stage valid bits, curve select to the square curve and mix
//   to zero; the curve tables are constant and need no initialization
`default_nettype none

module lut_waveshaper_mix #(
    parameter int TABLE_ENTRIES = lws_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    lws_req_if.sink                           request,
    lws_res_if.source                         result,
    input  wire logic                         cfg_we,
    input  wire logic [lws_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lws_pkg::CFG_W-1:0]    cfg_data
);
    import lws_pkg::*;

    logic [1:0]       curve_sel_reg;
    logic [MAG_W-1:0] mix_reg;

    logic front_valid;
    logic front_ready;
    idx_t front_data;
    logic interp_valid;
    logic interp_ready;
    wet_t interp_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_sel_reg <= CURVE_SQUARE;
            mix_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CURVE_SELECT: curve_sel_reg <= cfg_data[1:0];
                REG_MIX_AMOUNT:   mix_reg       <= cfg_data[MAG_W-1:0];
                default:          ;
            endcase
        end
    end

    lws_front #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (request.valid),
        .in_ready   (request.ready),
        .command    (request.command),
        .value      (request.value),
        .curve_sel  (curve_sel_reg),
        .mix_amount (mix_reg),
        .out_valid  (front_valid),
        .out_ready  (front_ready),
        .out_data   (front_data)
    );

    lws_interp #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (interp_valid),
        .out_ready (interp_ready),
        .out_data  (interp_data)
    );

    lws_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (interp_valid),
        .in_ready  (interp_ready),
        .in_data   (interp_data),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_value (result.shaped_value)
    );

    // input can only back up when the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !request.ready |-> (result.valid && !result.ready))
        else $error("input stalled while output side free");

    // shaped results stay within one in magnitude
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ($signed(result.shaped_value) >= -17'sd32768 &&
                          $signed(result.shaped_value) <= 17'sd32768))
        else $error("result out of range");

    // a held result stays unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready)
        |=> (result.valid && $stable(result.shaped_value)))
        else $error("held result changed");

endmodule

`default_nettype wire

@@ rtl/lws_front.sv @@
`default_nettype none

module lws_front #(
    parameter int TABLE_ENTRIES = lws_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     command,
    input  wire logic [lws_pkg::VALUE_W-1:0] value,
    input  wire logic [1:0]               curve_sel,
    input  wire logic [lws_pkg::MAG_W-1:0] mix_amount,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output lws_pkg::idx_t                 out_data
);
    import lws_pkg::*;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic [1:0]       sel;
        logic [MAG_W-1:0] w;
    } mag_t;

    logic s1_v_reg;
    logic s2_v_reg;
    logic s1_en;
    logic s2_en;
    mag_t s1_reg;
    mag_t s1_next;
    idx_t s2_reg;
    idx_t s2_next;

    logic signed [VALUE_W-1:0] v;
    logic        [VALUE_W-1:0] v_neg;

    assign s2_en    = !s2_v_reg || out_ready;
    assign s1_en    = !s1_v_reg || s2_en;
    assign in_ready = s1_en;

    // magnitude, sign and clamped mix
    always_comb
    begin
        v     = $signed(value);
        v_neg = VALUE_W'(0) - value;
        s1_next.neg = 1'b0;
        s1_next.mag = '0;
        if (command == CMD_ENVELOPE)
        begin
            if (v[VALUE_W-1])
                s1_next.mag = '0;
            else if (v > $signed({1'b0, Q15_ONE}))
                s1_next.mag = Q15_ONE;
            else
                s1_next.mag = value[MAG_W-1:0];
        end
        else
        begin
            s1_next.neg = v[VALUE_W-1];
            if (v > $signed({1'b0, Q15_ONE}))
                s1_next.mag = Q15_ONE;
            else if (!v[VALUE_W-1])
                s1_next.mag = value[MAG_W-1:0];
            else if (v < -$signed({1'b0, Q15_ONE}))
                s1_next.mag = Q15_ONE;
            else
                s1_next.mag = v_neg[MAG_W-1:0];
        end
        s1_next.sel = (curve_sel == CURVE_SINE || curve_sel == CURVE_LOG) ?
                      curve_sel : CURVE_SQUARE;
        s1_next.w   = (mix_amount > Q15_ONE) ? Q15_ONE : mix_amount;
    end

    // table position
    always_comb
    begin
        s2_next.prod = PROD_W'(s1_reg.mag) * PROD_W'(TABLE_ENTRIES - 1);
        s2_next.mag  = s1_reg.mag;
        s2_next.neg  = s1_reg.neg;
        s2_next.sel  = s1_reg.sel;
        s2_next.w    = s1_reg.w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_v_reg <= in_valid;
            if (s2_en)
                s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && in_valid)
            s1_reg <= s1_next;
        if (s2_en && s1_v_reg)
            s2_reg <= s2_next;
    end

    assign out_valid = s2_v_reg;
    assign out_data  = s2_reg;

endmodule

`default_nettype wire

@@ rtl/lws_interp.sv @@
`default_nettype none

module lws_interp #(
    parameter int TABLE_ENTRIES = lws_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire lws_pkg::idx_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output lws_pkg::wet_t      out_data
);
    import lws_pkg::*;

    localparam int          IDX_W    = $clog2(TABLE_ENTRIES);
    localparam logic [63:0] ROM_SPAN = 64'(TABLE_ENTRIES - 1);

    typedef logic [TABLE_ENTRIES-1:0][MAG_W-1:0] curve_rom_t;

    typedef struct packed {
        logic [MAG_W-1:0]  a;
        logic [MAG_W-1:0]  b;
        logic [FRAC_W-1:0] frac;
        logic              zero;
        logic              full;
        logic [MAG_W-1:0]  mag;
        logic              neg;
        logic [MAG_W-1:0]  w;
    } pick_t;

    typedef struct packed {
        logic [2*MAG_W-1:0] pa;
        logic [2*MAG_W-1:0] pb;
        logic               zero;
        logic               full;
        logic [MAG_W-1:0]   mag;
        logic               neg;
        logic [MAG_W-1:0]   w;
    } prod_t;

    function automatic curve_rom_t build_rom(input logic [1:0] curve);
        curve_rom_t  r;
        logic [63:0] t;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            t = (64'(i) << 30) / ROM_SPAN;
            case (curve)
                CURVE_SINE: r[i] = sine_point(t);
                CURVE_LOG:  r[i] = log_point(t);
                default:    r[i] = square_point(t);
            endcase
        end
        return r;
    endfunction

    localparam curve_rom_t ROM_SQUARE = build_rom(CURVE_SQUARE);
    localparam curve_rom_t ROM_SINE   = build_rom(CURVE_SINE);
    localparam curve_rom_t ROM_LOG    = build_rom(CURVE_LOG);

    logic  s3_v_reg;
    logic  s4_v_reg;
    logic  s5_v_reg;
    logic  s3_en;
    logic  s4_en;
    logic  s5_en;
    pick_t s3_reg;
    pick_t s3_next;
    prod_t s4_reg;
    prod_t s4_next;
    wet_t  s5_reg;
    wet_t  s5_next;

    logic [IDX_W-1:0]    idx;
    logic [IDX_W-1:0]    idx_hi;
    logic [MAG_W-1:0]    frac_inv;
    logic [2*MAG_W:0]    wsum;

    assign s5_en    = !s5_v_reg || out_ready;
    assign s4_en    = !s4_v_reg || s5_en;
    assign s3_en    = !s3_v_reg || s4_en;
    assign in_ready = s3_en;

    // neighbouring points
    always_comb
    begin
        idx    = in_data.prod[FRAC_W +: IDX_W];
        idx_hi = (idx == IDX_W'(TABLE_ENTRIES - 1)) ? idx : idx + 1'b1;
        case (in_data.sel)
            CURVE_SINE:
            begin
                s3_next.a = ROM_SINE[idx];
                s3_next.b = ROM_SINE[idx_hi];
            end
            CURVE_LOG:
            begin
                s3_next.a = ROM_LOG[idx];
                s3_next.b = ROM_LOG[idx_hi];
            end
            default:
            begin
                s3_next.a = ROM_SQUARE[idx];
                s3_next.b = ROM_SQUARE[idx_hi];
            end
        endcase
        s3_next.frac = in_data.prod[FRAC_W-1:0];
        s3_next.zero = (in_data.mag == '0);
        s3_next.full = (in_data.mag >= Q15_ONE);
        s3_next.mag  = in_data.mag;
        s3_next.neg  = in_data.neg;
        s3_next.w    = in_data.w;
    end

    // weighted points
    always_comb
    begin
        frac_inv     = Q15_ONE - {1'b0, s3_reg.frac};
        s4_next.pa   = s3_reg.a * frac_inv;
        s4_next.pb   = s3_reg.b * {1'b0, s3_reg.frac};
        s4_next.zero = s3_reg.zero;
        s4_next.full = s3_reg.full;
        s4_next.mag  = s3_reg.mag;
        s4_next.neg  = s3_reg.neg;
        s4_next.w    = s3_reg.w;
    end

    // interpolated curve value
    always_comb
    begin
        wsum = {1'b0, s4_reg.pa} + {1'b0, s4_reg.pb};
        if (s4_reg.zero)
            s5_next.wet = '0;
        else if (s4_reg.full)
            s5_next.wet = Q15_ONE;
        else
            s5_next.wet = wsum[FRAC_W +: MAG_W];
        s5_next.mag = s4_reg.mag;
        s5_next.neg = s4_reg.neg;
        s5_next.w   = s4_reg.w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
        end
        else
        begin
            if (s3_en)
                s3_v_reg <= in_valid;
            if (s4_en)
                s4_v_reg <= s3_v_reg;
            if (s5_en)
                s5_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_en && in_valid)
            s3_reg <= s3_next;
        if (s4_en && s3_v_reg)
            s4_reg <= s4_next;
        if (s5_en && s4_v_reg)
            s5_reg <= s5_next;
    end

    assign out_valid = s5_v_reg;
    assign out_data  = s5_reg;

endmodule

`default_nettype wire

@@ rtl/lws_blend.sv @@
`default_nettype none

module lws_blend (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire lws_pkg::wet_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [lws_pkg::VALUE_W-1:0] out_value
);
    import lws_pkg::*;

    typedef struct packed {
        logic [2*MAG_W-1:0] dry;
        logic [2*MAG_W-1:0] wet;
        logic               neg;
    } mixp_t;

    logic  s6_v_reg;
    logic  s7_v_reg;
    logic  s6_en;
    logic  s7_en;
    mixp_t s6_reg;
    mixp_t s6_next;
    logic [VALUE_W-1:0] s7_reg;
    logic [VALUE_W-1:0] s7_next;

    logic [MAG_W-1:0]   dry_w;
    logic [2*MAG_W:0]   msum;
    logic [MAG_W-1:0]   res;

    assign s7_en    = !s7_v_reg || out_ready;
    assign s6_en    = !s6_v_reg || s7_en;
    assign in_ready = s6_en;

    always_comb
    begin
        dry_w       = Q15_ONE - in_data.w;
        s6_next.dry = dry_w * in_data.mag;
        s6_next.wet = in_data.w * in_data.wet;
        s6_next.neg = in_data.neg;
    end

    // blend and sign restore
    always_comb
    begin
        msum = {1'b0, s6_reg.dry} + {1'b0, s6_reg.wet};
        res  = msum[FRAC_W +: MAG_W];
        if (s6_reg.neg)
            s7_next = VALUE_W'(0) - {1'b0, res};
        else
            s7_next = {1'b0, res};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_v_reg <= 1'b0;
            s7_v_reg <= 1'b0;
        end
        else
        begin
            if (s6_en)
                s6_v_reg <= in_valid;
            if (s7_en)
                s7_v_reg <= s6_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s6_en && in_valid)
            s6_reg <= s6_next;
        if (s7_en && s6_v_reg)
            s7_reg <= s7_next;
    end

    assign out_valid = s7_v_reg;
    assign out_value = s7_reg;

endmodule

`default_nettype wire
